FILE: rtl/base_memory_stack_allocator_top_defines.svh
// Assertion macros for the stack allocator checker.
// No dependencies; included by the checker file.
`ifndef BASE_MEMORY_STACK_ALLOCATOR_TOP_DEFINES_SVH
`define BASE_MEMORY_STACK_ALLOCATOR_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define BMSA_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define BMSA_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/bmsa_pkg.sv
// Shared types and constants for the stack allocator.
// No dependencies; used by the top level and the checker.
`timescale 1ns / 1ps
`default_nettype none

package bmsa_pkg;

    localparam int KB_SHIFT = 10;
    localparam int CNT_W    = 10;   // free counter width
    localparam int MARK_W   = 11;   // stored run length width
    localparam int ADDR_W   = 20;   // byte address / size width

    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

    typedef struct packed {
        logic              func;
        logic [ADDR_W-1:0] size_bytes;
        logic [ADDR_W-1:0] address;
    } req_t;

    typedef struct packed {
        logic              ok;
        logic [ADDR_W-1:0] block_address;
        logic [CNT_W-1:0]  free_kb;
    } rsp_t;

endpackage

`default_nettype wire

FILE: rtl/bmsa_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module bmsa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                     clk,
    input  wire logic                                     we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                         wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

FILE: rtl/base_memory_stack_allocator_top.sv
// Stack allocator over a region of kilobyte blocks with deferred free.
// Depends on bmsa_pkg and bmsa_ram.
`timescale 1ns / 1ps
`default_nettype none

//  channel   ports                     handshake
//  request   start, req                taken when start && !busy
//  result    done, rsp                 done high one cycle, no back-pressure
//  config    cfg_we, cfg_wdata         written on any edge with cfg_we
//
//  After reset the mark memory is swept to zero, with busy high.
//  After accept: allocate runs R reclaim steps, a fit check, then clears marks of
//  the K blocks taken (0 on failure); free writes M marks, then R reclaim steps.
//  A reclaim read at the top skips its check; a free of size 0 only reports.
//  One mark-memory access per cycle; a reclaim step is a read plus a data check.
//  One request at a time; the result strobe cannot be held off.

module base_memory_stack_allocator_top #(
    parameter int TOTAL_KB = 640
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    output logic                             busy,
    input  wire bmsa_pkg::req_t              req,
    output logic                             done,
    output bmsa_pkg::rsp_t                   rsp,
    input  wire logic                        cfg_we,
    input  wire logic [bmsa_pkg::CNT_W-1:0]  cfg_wdata
);

    import bmsa_pkg::*;

    localparam int AW    = (TOTAL_KB > 1) ? $clog2(TOTAL_KB) : 1;
    localparam int IDX_W = 12;   // block index: first kB plus run length

    localparam logic [IDX_W-1:0] TOP_IDX = IDX_W'(TOTAL_KB);
    localparam logic [CNT_W-1:0] TOP_CNT = CNT_W'(TOTAL_KB);

    // sequencer states
    localparam logic [2:0] S_CLEAR  = 3'd0;   // zero the mark memory
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_RC_RD  = 3'd2;   // reclaim: read mark at counter
    localparam logic [2:0] S_RC_CHK = 3'd3;   // reclaim: test read data
    localparam logic [2:0] S_ALLOC  = 3'd4;   // fit check, lower counter
    localparam logic [2:0] S_A_CLR  = 3'd5;   // clear marks of taken blocks
    localparam logic [2:0] S_F_MARK = 3'd6;   // write count-down run lengths
    localparam logic [2:0] S_FIN    = 3'd7;   // report ignored free

    logic [2:0]        state_reg, state_next;
    logic [CNT_W-1:0]  fc_reg, fc_next;        // free counter
    logic              func_reg, func_next;
    logic [MARK_W-1:0] kb_reg, kb_next;        // requested kB
    logic [MARK_W-1:0] run_reg, run_next;      // remaining run / value to write
    logic [IDX_W-1:0]  idx_reg, idx_next;      // walking block index
    logic              done_reg, done_next;
    rsp_t              rsp_reg, rsp_next;

    // mark memory port
    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [MARK_W-1:0] mem_wdata;
    logic [AW-1:0]     mem_raddr;
    logic [MARK_W-1:0] mem_rdata;

    // arithmetic
    logic [ADDR_W:0]   kb_sum;       // byte size rounded up, before shift
    logic [IDX_W-1:0]  rc_sum;       // counter plus run length
    logic [CNT_W-1:0]  fc_less;      // counter minus request

    bmsa_ram #(
        .WIDTH (MARK_W),
        .DEPTH (TOTAL_KB)
    ) u_marks (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // Rounding: alloc adds 1023; free also adds the offset inside the first kB.
    always_comb
    begin
        if (req.func == FUNC_FREE)
        begin
            kb_sum = {1'b0, req.size_bytes}
                   + (ADDR_W + 1)'(req.address[KB_SHIFT-1:0])
                   + (ADDR_W + 1)'(10'h3FF);
        end
        else
        begin
            kb_sum = {1'b0, req.size_bytes} + (ADDR_W + 1)'(10'h3FF);
        end
    end

    assign rc_sum  = IDX_W'(fc_reg) + IDX_W'(mem_rdata);
    assign fc_less = fc_reg - kb_reg[CNT_W-1:0];

    always_comb
    begin
        state_next = state_reg;
        fc_next    = fc_reg;
        func_next  = func_reg;
        kb_next    = kb_reg;
        run_next   = run_reg;
        idx_next   = idx_reg;
        done_next  = 1'b0;
        rsp_next   = rsp_reg;
        mem_we     = 1'b0;
        mem_waddr  = idx_reg[AW-1:0];
        mem_wdata  = '0;
        mem_raddr  = fc_reg[AW-1:0];

        unique case (state_reg)
            S_CLEAR:
            begin
                mem_we = 1'b1;
                if (idx_reg == TOP_IDX - IDX_W'(1))
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end

            S_IDLE:
            begin
                if (start)
                begin
                    func_next = req.func;
                    kb_next   = kb_sum[ADDR_W -: MARK_W];
                    run_next  = kb_sum[ADDR_W -: MARK_W];
                    idx_next  = IDX_W'(req.address[ADDR_W-1:KB_SHIFT]);
                    if (req.func == FUNC_ALLOC)
                    begin
                        state_next = S_RC_RD;
                    end
                    else if (req.size_bytes == '0)
                    begin
                        state_next = S_FIN;   // zero size: no effect
                    end
                    else
                    begin
                        state_next = S_F_MARK;
                    end
                end
            end

            S_F_MARK:
            begin
                mem_we    = (idx_reg < TOP_IDX);   // drop marks past the top
                mem_wdata = run_reg;
                if (run_reg == MARK_W'(1))
                begin
                    state_next = S_RC_RD;
                end
                else
                begin
                    idx_next = idx_reg + IDX_W'(1);
                    run_next = run_reg - MARK_W'(1);
                end
            end

            S_RC_RD:
            begin
                if (fc_reg < TOP_CNT)
                begin
                    state_next = S_RC_CHK;
                end
                else if (func_reg == FUNC_ALLOC)
                begin
                    state_next = S_ALLOC;
                end
                else
                begin
                    state_next    = S_IDLE;
                    done_next     = 1'b1;
                    rsp_next      = '{ok: 1'b1, block_address: '0, free_kb: fc_reg};
                end
            end

            S_RC_CHK:
            begin
                if (mem_rdata != '0)
                begin
                    fc_next    = (rc_sum > TOP_IDX) ? TOP_CNT : rc_sum[CNT_W-1:0];
                    state_next = S_RC_RD;
                end
                else if (func_reg == FUNC_ALLOC)
                begin
                    state_next = S_ALLOC;
                end
                else
                begin
                    state_next = S_IDLE;
                    done_next  = 1'b1;
                    rsp_next   = '{ok: 1'b1, block_address: '0, free_kb: fc_reg};
                end
            end

            S_ALLOC:
            begin
                if (kb_reg > MARK_W'(fc_reg))
                begin
                    state_next = S_IDLE;
                    done_next  = 1'b1;
                    rsp_next   = '{ok: 1'b0, block_address: '0, free_kb: fc_reg};
                end
                else
                begin
                    fc_next  = fc_less;
                    idx_next = IDX_W'(fc_less);
                    run_next = kb_reg;
                    if (kb_reg == '0)
                    begin
                        // zero-size allocate: report the counter, take nothing
                        state_next = S_IDLE;
                        done_next  = 1'b1;
                        rsp_next   = '{ok: 1'b1,
                                       block_address: {fc_less, {KB_SHIFT{1'b0}}},
                                       free_kb: fc_less};
                    end
                    else
                    begin
                        state_next = S_A_CLR;
                    end
                end
            end

            S_A_CLR:
            begin
                mem_we = (idx_reg < TOP_IDX);
                if (run_reg == MARK_W'(1))
                begin
                    state_next = S_IDLE;
                    done_next  = 1'b1;
                    rsp_next   = '{ok: 1'b1,
                                   block_address: {fc_reg, {KB_SHIFT{1'b0}}},
                                   free_kb: fc_reg};
                end
                else
                begin
                    idx_next = idx_reg + IDX_W'(1);
                    run_next = run_reg - MARK_W'(1);
                end
            end

            S_FIN:
            begin
                state_next = S_IDLE;
                done_next  = 1'b1;
                rsp_next   = '{ok: 1'b1, block_address: '0, free_kb: fc_reg};
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // register write reloads the counter
        if (cfg_we)
        begin
            fc_next = cfg_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            fc_reg    <= TOP_CNT;
            func_reg  <= FUNC_ALLOC;
            idx_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            fc_reg    <= fc_next;
            func_reg  <= func_next;
            idx_reg   <= idx_next;
            done_reg  <= done_next;
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        kb_reg  <= kb_next;
        run_reg <= run_next;
        rsp_reg <= rsp_next;
    end

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;
    assign rsp  = rsp_reg;

endmodule

`default_nettype wire

FILE: rtl/bmsa_checker.sv
// Port-level checks for the stack allocator, bound to the top level.
// Depends on bmsa_pkg and base_memory_stack_allocator_top_defines.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "base_memory_stack_allocator_top_defines.svh"

module bmsa_checker (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    input  wire logic                        busy,
    input  wire bmsa_pkg::req_t              req,
    input  wire logic                        done,
    input  wire bmsa_pkg::rsp_t              rsp,
    input  wire logic                        cfg_we,
    input  wire logic [bmsa_pkg::CNT_W-1:0]  cfg_wdata
);

    import bmsa_pkg::*;

    `BMSA_ASSERT_NXT(a_accept_busy, start && !busy, busy, "accepted request did not raise busy")
    `BMSA_ASSERT_IMP(a_done_after_work, done, $past(busy), "result without work in progress")
    `BMSA_ASSERT_NXT(a_done_single, done, !done, "result strobe longer than one cycle")
    `BMSA_ASSERT_IMP(a_fail_no_addr, done && !rsp.ok, rsp.block_address == '0, "failed alloc with address")
    `BMSA_ASSERT_IMP(a_addr_aligned, done, rsp.block_address[KB_SHIFT-1:0] == '0, "address not kB aligned")

endmodule

bind base_memory_stack_allocator_top bmsa_checker u_bmsa_checker (.*);

`default_nettype wire

FILE: tb/stack_alloc_checker.sv
// Checker for the stack allocator: follows the request, result and config
// channels, keeps its own allocator state and compares every result.
// Depends on bmsa_pkg.
`timescale 1ns / 1ps

module stack_alloc_checker #(
    parameter int TOTAL_KB = 640
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    input  wire logic                        busy,
    input  wire bmsa_pkg::req_t              req,
    input  wire logic                        done,
    input  wire bmsa_pkg::rsp_t              rsp,
    input  wire logic                        cfg_we,
    input  wire logic [bmsa_pkg::CNT_W-1:0]  cfg_wdata,
    output int unsigned                      mismatches,
    output int unsigned                      outstanding
);
    import bmsa_pkg::*;

    localparam int unsigned KB_MASK   = 1023;
    localparam int unsigned MAX_NOTES = 10;

    logic [CNT_W-1:0]  kb_free;             // bottom of the in-use area
    logic [MARK_W-1:0] run_len [TOTAL_KB];  // 0 = in use, else deferred-free run
    rsp_t              owed_rsp [$];

    function automatic void clear_state();
        kb_free = CNT_W'(TOTAL_KB);
        foreach (run_len[i])
            run_len[i] = '0;
    endfunction

    // Walk marked runs upward from the counter, clamp at the top.
    function automatic void reclaim_runs();
        int unsigned nxt;
        while (kb_free < TOTAL_KB && run_len[kb_free] != '0)
        begin
            nxt = 32'(kb_free) + 32'(run_len[kb_free]);
            kb_free = (nxt > TOTAL_KB) ? CNT_W'(TOTAL_KB) : CNT_W'(nxt);
        end
    endfunction

    function automatic rsp_t apply_request(req_t r);
        rsp_t        res;
        int unsigned kb;
        int unsigned first;
        int unsigned off;
        int unsigned b;
        int unsigned i;
        res.ok = 1'b1;
        res.block_address = '0;
        if (r.func == FUNC_ALLOC)
        begin
            kb = (32'(r.size_bytes) + KB_MASK) >> KB_SHIFT;
            reclaim_runs();
            if (kb > kb_free)
                res.ok = 1'b0;
            else
            begin
                kb_free = kb_free - CNT_W'(kb);
                res.block_address = ADDR_W'(32'(kb_free) << KB_SHIFT);
                for (i = 0; i < kb; i++)
                begin
                    b = 32'(kb_free) + i;
                    if (b < TOTAL_KB)
                        run_len[b] = '0;
                end
            end
        end
        else if (r.size_bytes != '0)
        begin
            off   = 32'(r.address) & KB_MASK;
            kb    = (32'(r.size_bytes) + off + KB_MASK) >> KB_SHIFT;
            first = 32'(r.address) >> KB_SHIFT;
            for (i = 0; i < kb; i++)
            begin
                b = first + i;
                if (b < TOTAL_KB)
                    run_len[b] = MARK_W'(kb - i);
            end
            reclaim_runs();
        end
        res.free_kb = kb_free;
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        rsp_t want;
        if (!rst_n)
        begin
            clear_state();
            owed_rsp.delete();
            mismatches = 0;
        end
        else
        begin
            if (cfg_we)
                kb_free = cfg_wdata;
            if (done)
            begin
                if (owed_rsp.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= MAX_NOTES)
                        $display("%0t: result with no request pending: ok=%0d addr=%0d kb=%0d",
                                 $realtime, rsp.ok, rsp.block_address, rsp.free_kb);
                end
                else
                begin
                    want = owed_rsp.pop_front();
                    if (rsp.ok !== want.ok || rsp.block_address !== want.block_address
                        || rsp.free_kb !== want.free_kb)
                    begin
                        mismatches++;
                        if (mismatches <= MAX_NOTES)
                            $display({"%0t: result mismatch: expected ok=%0d addr=%0d kb=%0d,",
                                      " got ok=%0d addr=%0d kb=%0d"},
                                     $realtime, want.ok, want.block_address, want.free_kb,
                                     rsp.ok, rsp.block_address, rsp.free_kb);
                    end
                end
            end
            if (start && !busy)
                owed_rsp.push_back(apply_request(req));
        end
        outstanding = owed_rsp.size();
    end

endmodule

FILE: tb/tb.sv
// Top of the stack allocator testbench: clock, reset, request stimulus and
// the verdict. Depends on bmsa_pkg, the allocator top and stack_alloc_checker.
`timescale 1ns / 1ps

module tb;
    import bmsa_pkg::*;

    localparam int          TOTAL_KB     = 640;
    localparam int unsigned KB           = 1024;
    localparam int unsigned REGION_BYTES = TOTAL_KB * KB;
    localparam int unsigned TOP_ADDR     = REGION_BYTES - 1;
    // Worst request marks 641 blocks and reclaims 640 runs; the limit covers
    // about 900 requests of that, taken several times over.
    localparam int unsigned CYCLE_LIMIT  = 8_000_000;
    localparam int unsigned QUIET_CYCLES = 2000;

    // A block handed out by the allocator and not yet given back.
    typedef struct {
        int unsigned base;
        int unsigned len;
    } grant_t;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               start;
    logic               busy;
    req_t               req;
    logic               done;
    rsp_t               rsp;
    logic               cfg_we;
    logic [CNT_W-1:0]   cfg_wdata;

    int unsigned        mismatches;
    int unsigned        outstanding;
    int unsigned        cycles = 0;
    int unsigned        idle_pct = 0;   // chance per cycle that the sender holds off

    grant_t             live_grants [$];
    req_t               issued [$];

    base_memory_stack_allocator_top #(
        .TOTAL_KB (TOTAL_KB)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .req       (req),
        .done      (done),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    stack_alloc_checker #(
        .TOTAL_KB (TOTAL_KB)
    ) u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .req         (req),
        .done        (done),
        .rsp         (rsp),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Run guard: a hang anywhere ends the run as a failure.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("base_memory_stack_allocator_top regression: fail");
            $finish;
        end
    end

    // Tracks granted blocks so the stimulus can give them back later, in
    // any order. Requests and results pair up in order, one at a time.
    always @(posedge clk)
    begin
        req_t last;
        if (done && issued.size() != 0)
        begin
            last = issued.pop_front();
            // Blocks granted above the region (counter loaded past the top)
            // have addresses the free request cannot carry; skip them.
            if (last.func == FUNC_ALLOC && rsp.ok && last.size_bytes != '0
                && rsp.block_address < REGION_BYTES)
                live_grants.push_back('{base: rsp.block_address, len: last.size_bytes});
        end
        if (rst_n && start && !busy)
            issued.push_back(req);
    end

    // Present one request and hold it until taken. Entered and left just
    // after a falling edge; start is touched once per time step.
    task automatic send_req(input logic f, input int unsigned size, input int unsigned addr);
        while ($urandom_range(99, 0) < idle_pct)
        begin
            start <= 1'b0;
            @(negedge clk);
        end
        start <= 1'b1;
        req   <= '{func: f, size_bytes: ADDR_W'(size), address: ADDR_W'(addr)};
        @(posedge clk);
        while (busy)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Drop start and wait until every request has its result and the
    // block has gone idle.
    task automatic drain();
        start <= 1'b0;
        @(negedge clk);
        while (outstanding != 0 || busy)
            @(negedge clk);
    endtask

    // Load the free counter through the config channel, so the
    // grants tracked so far no longer mean anything.
    task automatic load_start_kb(input int unsigned kb);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= CNT_W'(kb);
        @(negedge clk);
        cfg_we    <= 1'b0;
        live_grants.delete();
    endtask

    // Mixed traffic: allocations of mostly small sizes, frees of live
    // grants in random order (so runs are left behind and reclaimed in
    // chains), a few unaligned frees, null frees and arbitrary frees.
    task automatic random_traffic(input int unsigned count);
        int unsigned roll;
        int unsigned pick;
        int unsigned off;
        int unsigned size;
        grant_t      g;
        for (int unsigned n = 0; n < count; n++)
        begin
            roll = $urandom_range(99, 0);
            if (roll < 3)
                send_req(FUNC_FREE, 0, $urandom_range(TOP_ADDR, 0));
            else if (roll < 48 && live_grants.size() != 0)
            begin
                pick = $urandom_range(live_grants.size() - 1, 0);
                g = live_grants[pick];
                live_grants.delete(pick);
                off = 0;
                if (g.len > 1 && $urandom_range(3, 0) == 0)
                    off = $urandom_range(g.len - 1, 1);
                send_req(FUNC_FREE, g.len - off, g.base + off);
            end
            else if (roll < 60)
            begin
                // free of an arbitrary range: memory the allocator never
                // handed out here, or parts of it that overlap live grants
                size = ($urandom_range(19, 0) == 0) ? $urandom_range(REGION_BYTES, 1)
                                                     : $urandom_range(16 * KB, 1);
                send_req(FUNC_FREE, size, $urandom_range(TOP_ADDR, 0));
            end
            else
            begin
                roll = $urandom_range(99, 0);
                if (roll < 3)
                    size = 0;
                else if (roll < 6)
                    size = $urandom_range(REGION_BYTES, 0);
                else
                    size = $urandom_range(8 * KB, 1);
                send_req(FUNC_ALLOC, size, $urandom_range(TOP_ADDR, 0));
            end
        end
    endtask

    initial
    begin
        start     = 1'b0;
        req       = '0;
        cfg_we    = 1'b0;
        cfg_wdata = '0;
        rst_n     = 1'b0;
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;

        // Directed part, counter at its reset value. The first request waits
        // out the mark-memory sweep through busy.
        send_req(FUNC_ALLOC, 0, 0);                    // zero size: nothing taken
        send_req(FUNC_ALLOC, 1, TOP_ADDR);             // one byte rounds to 1 kB, 639
        send_req(FUNC_ALLOC, KB, 0);                   // exactly 1 kB, 638
        send_req(FUNC_ALLOC, KB + 1, 0);               // just over: 2 kB, 636
        send_req(FUNC_FREE, 0, TOP_ADDR);              // zero size: no effect
        send_req(FUNC_FREE, KB, 638 * KB);             // not at the bottom: deferred
        send_req(FUNC_FREE, KB + 1, 636 * KB);         // bottom: chains into 638
        send_req(FUNC_ALLOC, REGION_BYTES, 0);         // too big, fails
        send_req(FUNC_FREE, 1, 639 * KB);              // last block back
        send_req(FUNC_ALLOC, REGION_BYTES, 0);         // whole region
        send_req(FUNC_ALLOC, 1, 0);                    // nothing left, fails
        send_req(FUNC_FREE, REGION_BYTES, 0);          // whole region in one free
        send_req(FUNC_ALLOC, 4 * KB, 0);               // 636
        send_req(FUNC_FREE, 4 * KB - 700, 636 * KB + 700);  // unaligned start
        send_req(FUNC_FREE, REGION_BYTES, TOP_ADDR);   // runs past the top, rest dropped
        send_req(FUNC_ALLOC, 2 * KB, 0);

        // Counter loaded above the top: reclaim stays off until it drops.
        load_start_kb(1023);
        send_req(FUNC_ALLOC, 1, 0);
        send_req(FUNC_FREE, KB, 639 * KB);
        send_req(FUNC_ALLOC, REGION_BYTES, 0);
        send_req(FUNC_ALLOC, 2 * KB, 0);

        // Empty pool: allocation only succeeds after frees reclaim.
        load_start_kb(0);
        send_req(FUNC_ALLOC, 0, 0);
        send_req(FUNC_ALLOC, 1, 0);
        send_req(FUNC_FREE, 1, 0);
        send_req(FUNC_ALLOC, KB, 0);

        // Random phases, each with its own counter load and sender pacing.
        load_start_kb(TOTAL_KB);
        idle_pct = 7;
        random_traffic(300);

        load_start_kb(0);
        idle_pct = 83;
        random_traffic(160);

        load_start_kb(1023);
        idle_pct = 0;
        random_traffic(200);

        load_start_kb($urandom_range(TOTAL_KB - 1, 1));
        random_traffic(190);

        drain();
        // Look for stray results after the last expected one.
        repeat (QUIET_CYCLES) @(negedge clk);

        if (mismatches == 0 && outstanding == 0)
            $display("base_memory_stack_allocator_top regression: pass");
        else
            $display("base_memory_stack_allocator_top regression: fail");
        $finish;
    end

endmodule
